// File: hdl/ppss_pkg.sv
// Shared types and constants for the preemptive priority mode stack.
package ppss_pkg;

   localparam int MODE_W   = 3;
   localparam int KIND_W   = 2;
   localparam int PRIO_W   = 3;
   localparam int DEPTH_W  = 4;
   localparam int TABLE_W  = 21;

   localparam logic [MODE_W-1:0]  NUM_MODES    = 3'd7;
   localparam logic [MODE_W-1:0]  MODE_STANDBY = 3'd0;
   localparam logic [TABLE_W-1:0] PRIO_RESET   = 21'd1754760;

   // Event kinds carried on the request channel.
   localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FORCE   = 2'd2;

   typedef struct packed {
      logic                transitioned;
      logic [MODE_W-1:0]   exited_state;
      logic [MODE_W-1:0]   current_state;
      logic [DEPTH_W-1:0]  stack_depth;
   } result_type;

   // Priority of a mode out of the packed table; mode 7 has none.
   function automatic logic [PRIO_W-1:0] prio_of(input logic [TABLE_W-1:0] table_bits,
                                                 input logic [MODE_W-1:0]  mode);
      logic [PRIO_W-1:0] prio;
      unique case (mode)
         3'd0:    prio = table_bits[2:0];
         3'd1:    prio = table_bits[5:3];
         3'd2:    prio = table_bits[8:6];
         3'd3:    prio = table_bits[11:9];
         3'd4:    prio = table_bits[14:12];
         3'd5:    prio = table_bits[17:15];
         3'd6:    prio = table_bits[20:18];
         default: prio = '0;
      endcase
      return prio;
   endfunction

endpackage

// File: hdl/ppss_engine.sv
// Mode state, saved-mode stack and the per-event next-state logic.
module ppss_engine #(
   parameter int STACK_DEPTH = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step_valid,
   input  logic [ppss_pkg::KIND_W-1:0]   step_kind,
   input  logic [ppss_pkg::MODE_W-1:0]   step_mode,
   input  logic [ppss_pkg::TABLE_W-1:0]  prio_table,
   output ppss_pkg::result_type          step_result
);
   import ppss_pkg::*;

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W = $clog2(STACK_DEPTH);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);

   logic [MODE_W-1:0] active_ff, active_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [MODE_W-1:0] saved_ff [STACK_DEPTH];

   logic              push;
   logic [CNT_W-1:0]  count_dec;
   logic [MODE_W-1:0] top_mode;
   logic [MODE_W-1:0] exited;
   logic              moved;

   assign count_dec = count_ff - CNT_W'(1);
   assign top_mode  = saved_ff[count_dec[IDX_W-1:0]];

   always_comb begin
      active_in = active_ff;
      count_in  = count_ff;
      exited    = MODE_STANDBY;
      moved     = 1'b0;
      push      = 1'b0;
      unique case (step_kind)
         KIND_REQUEST: begin
            if (step_mode != NUM_MODES && step_mode != active_ff &&
                prio_of(prio_table, step_mode) > prio_of(prio_table, active_ff) &&
                count_ff < CNT_FULL) begin
               push      = 1'b1;
               exited    = active_ff;
               active_in = step_mode;
               count_in  = count_ff + CNT_W'(1);
               moved     = 1'b1;
            end
         end
         KIND_RELEASE: begin
            exited = active_ff;
            moved  = 1'b1;
            if (count_ff != '0) begin
               count_in  = count_dec;
               active_in = (top_mode == NUM_MODES) ? MODE_STANDBY : top_mode;
            end else begin
               count_in  = '0;
               active_in = MODE_STANDBY;
            end
         end
         KIND_FORCE: begin
            exited    = active_ff;
            moved     = 1'b1;
            count_in  = '0;
            active_in = MODE_STANDBY;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      step_result.transitioned  = moved;
      step_result.exited_state  = exited;
      step_result.current_state = active_in;
      step_result.stack_depth   = DEPTH_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= MODE_STANDBY;
         count_ff  <= '0;
      end else if (step_valid) begin
         active_ff <= active_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_valid && push) begin
         saved_ff[count_ff[IDX_W-1:0]] <= active_ff;
      end
   end

endmodule

// File: hdl/preemptive_priority_state_stack_core.sv
// Top level of the preemptive priority mode arbiter with its nesting stack.
//
// Usage: each request-channel transaction carries one event. req_tuser holds
// the event kind (request a mode, release, force standby) and req_tdata the
// requested mode. Every event produces exactly one response transaction that
// reports whether a transition took place, the mode that was left, the mode
// now active and the number of saved (preempted) modes.
// The priority table is written through csr_wr_en / csr_wr_data while the
// block is idle; it takes effect for the next event.
// An event is captured in the input register; when it advances, the mode
// logic updates its state and loads the response register. Throughput is
// one event per cycle while the receiver does not stall.
// Reset returns the block to standby with an empty stack and loads the
// default table, in which mode i has priority i. When the receiver stalls,
// the response register holds its transaction and the input register still
// takes one more event; after that req_tready drops until rsp_tready rises.
module preemptive_priority_state_stack_core #(
   parameter int STACK_DEPTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [2:0] requested_state, [7:3] zero
   input  logic [1:0]  req_tuser,   // [1:0] kind
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [0] transitioned, [3:1] exited_state,
                                    // [6:4] current_state, [10:7] stack_depth,
                                    // [15:11] zero
   // Configuration port for the priority table.
   input  logic        csr_wr_en,
   input  logic [20:0] csr_wr_data
);
   import ppss_pkg::*;

   // Input register stage.
   logic              in_valid_ff, in_valid_in;
   logic [KIND_W-1:0] in_kind_ff;
   logic [MODE_W-1:0] in_mode_ff;

   // Response register stage.
   logic              out_valid_ff, out_valid_in;
   result_type        out_result_ff;

   logic [TABLE_W-1:0] prio_ff;

   logic       req_take;
   logic       advance;
   result_type step_result;

   // The captured event moves on when the response register is free or its
   // transaction completes in this cycle.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         prio_ff      <= PRIO_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            prio_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers carry no reset; the valid bits qualify them.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_kind_ff <= req_tuser;
         in_mode_ff <= req_tdata[MODE_W-1:0];
      end
      if (advance) begin
         out_result_ff <= step_result;
      end
   end

   ppss_engine #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .step_valid  (advance),
      .step_kind   (in_kind_ff),
      .step_mode   (in_mode_ff),
      .prio_table  (prio_ff),
      .step_result (step_result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'b0,
                        out_result_ff.stack_depth,
                        out_result_ff.current_state,
                        out_result_ff.exited_state,
                        out_result_ff.transitioned};

endmodule
